>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the index counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define ASSERT_AT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked assertion on the block's own clk and arst_n.
`define ASSERT_CLK(lbl, prop, msg) `ASSERT_AT(lbl, clk, arst_n, prop, msg)

`endif

>>> hw/rtl/mdic_pkg.sv
// Package: constants, types and register codes of the index counter.
`default_nettype none

package mdic_pkg;

	localparam int NumDims     = 4;
	localparam int HwDims      = 4;
	localparam int SizeBits    = 12;
	localparam int CountW      = 48;
	localparam int CfgIdxW     = 3;
	localparam int ActiveDims  = (NumDims < HwDims) ? NumDims : HwDims;
	localparam int FirstActive = HwDims - ActiveDims;

	typedef logic [SizeBits-1:0] size_t;
	typedef logic [CountW-1:0]   count_t;

	localparam count_t CountMax = '1;

	typedef enum logic [CfgIdxW-1:0] {
		RegSizeDim0  = CfgIdxW'(0),
		RegSizeDim1  = CfgIdxW'(1),
		RegSizeDim2  = CfgIdxW'(2),
		RegSizeDim3  = CfgIdxW'(3),
		RegStepLimit = CfgIdxW'(4),
		RegAutoLimit = CfgIdxW'(5)
	} cfg_reg_t;

	typedef struct packed {
		logic               tok;
		logic [HwDims-1:0]  mask;
		count_t             acc;
		count_t             prod;
	} cell_link_t;

endpackage

`default_nettype wire

>>> hw/rtl/mdic_cell.sv
// One digit cell: holds a digit, does one Horner and limit step, ripples the carry.
`default_nettype none

module mdic_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  mdic_pkg::size_t       size,
	input  wire                   hold,
	input  wire                   adv,
	input  wire                   carry_in,
	output logic                  carry_out,
	input  mdic_pkg::cell_link_t  link_in,
	output mdic_pkg::cell_link_t  link_out,
	output mdic_pkg::size_t       digit
);

	mdic_pkg::size_t   digit_q;
	logic              tok_q;
	logic [mdic_pkg::HwDims-1:0] mask_q;
	mdic_pkg::count_t  acc_q;
	mdic_pkg::count_t  prod_q;

	logic [mdic_pkg::SizeBits:0]                  nxt;
	logic                                         wrap;
	logic [mdic_pkg::CountW+mdic_pkg::SizeBits-1:0] acc_mul;
	logic [mdic_pkg::CountW+mdic_pkg::SizeBits-1:0] prod_mul;
	mdic_pkg::count_t  acc_nxt;
	mdic_pkg::count_t  prod_nxt;

	always_comb begin
		nxt       = {1'b0, digit_q} + 1'b1;
		wrap      = nxt >= {1'b0, size};
		carry_out = carry_in & wrap;
		acc_mul   = link_in.acc * size;
		prod_mul  = link_in.prod * size;
		if (link_in.mask[0]) begin
			acc_nxt = link_in.acc;
		end else begin
			acc_nxt = acc_mul[mdic_pkg::CountW-1:0] + mdic_pkg::CountW'(digit_q);
		end
		if (size == '0) begin
			prod_nxt = link_in.prod;
		end else begin
			prod_nxt = prod_mul[mdic_pkg::CountW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			tok_q   <= 1'b0;
		end else begin
			if (!hold) begin
				tok_q <= link_in.tok;
			end
			if (adv && carry_in) begin
				digit_q <= wrap ? '0 : nxt[mdic_pkg::SizeBits-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (link_in.tok && !hold) begin
			mask_q <= link_in.mask >> 1;
			acc_q  <= acc_nxt;
			prod_q <= prod_nxt;
		end
	end

	assign link_out.tok  = tok_q;
	assign link_out.mask = mask_q;
	assign link_out.acc  = acc_q;
	assign link_out.prod = prod_q;
	assign digit         = digit_q;

endmodule

`default_nettype wire

>>> hw/rtl/mdic_cfg.sv
// Configuration registers: dimension sizes, step limit and auto-limit mode.
`default_nettype none

module mdic_cfg (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [mdic_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire [mdic_pkg::CountW-1:0]    cfg_wr_data,
	output mdic_pkg::size_t               size [mdic_pkg::HwDims],
	output mdic_pkg::count_t              step_limit,
	output logic                          auto_limit
);

	mdic_pkg::size_t   size_q [mdic_pkg::HwDims];
	mdic_pkg::count_t  step_limit_q;
	logic              auto_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < mdic_pkg::HwDims; d++) begin
				size_q[d] <= mdic_pkg::SizeBits'(1);
			end
			step_limit_q <= mdic_pkg::CountW'(1);
			auto_limit_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (mdic_pkg::cfg_reg_t'(cfg_index))
				mdic_pkg::RegSizeDim0:  size_q[0] <= cfg_wr_data[mdic_pkg::SizeBits-1:0];
				mdic_pkg::RegSizeDim1:  size_q[1] <= cfg_wr_data[mdic_pkg::SizeBits-1:0];
				mdic_pkg::RegSizeDim2:  size_q[2] <= cfg_wr_data[mdic_pkg::SizeBits-1:0];
				mdic_pkg::RegSizeDim3:  size_q[3] <= cfg_wr_data[mdic_pkg::SizeBits-1:0];
				mdic_pkg::RegStepLimit: step_limit_q <= cfg_wr_data;
				mdic_pkg::RegAutoLimit: auto_limit_q <= cfg_wr_data[0];
				default: ;
			endcase
		end
	end

	assign size       = size_q;
	assign step_limit = step_limit_q;
	assign auto_limit = auto_limit_q;

endmodule

`default_nettype wire

>>> hw/rtl/multi_dim_index_counter.sv
// Top level: mixed-radix index counter with row-major linear index.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   cfg      | cfg_wr_en              | cfg_index, cfg_wr_data
//   in       | in_valid / in_ready    | exclude_mask
//   out      | out_valid / out_ready  | index_dim0..3, linear_index, step_count, finished
//
// A transaction walks the four-cell chain, where each cell does one 48x12 multiply-add,
// and then loads the output register.
// The digits advance when the output register loads; the next input is taken once
// the chain is empty, while a loaded result may still wait for out_ready.
// A stalled result holds the transaction in the last cell.
// Reset: digits and step count zero, sizes 1, step limit 1, auto limit on.
`default_nettype none

`include "assert_macros.svh"

module multi_dim_index_counter (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wr_en,
	input  wire [mdic_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire [mdic_pkg::CountW-1:0]    cfg_wr_data,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire [mdic_pkg::HwDims-1:0]    exclude_mask,
	output logic                          out_valid,
	input  wire                           out_ready,
	output logic [mdic_pkg::SizeBits-1:0] index_dim0,
	output logic [mdic_pkg::SizeBits-1:0] index_dim1,
	output logic [mdic_pkg::SizeBits-1:0] index_dim2,
	output logic [mdic_pkg::SizeBits-1:0] index_dim3,
	output logic [mdic_pkg::CountW-1:0]   linear_index,
	output logic [mdic_pkg::CountW-1:0]   step_count,
	output logic                          finished
);

	mdic_pkg::size_t       cfg_size [mdic_pkg::HwDims];
	mdic_pkg::size_t       eff_size [mdic_pkg::HwDims];
	mdic_pkg::size_t       digit    [mdic_pkg::HwDims];
	mdic_pkg::count_t      step_limit;
	logic                  auto_limit;
	mdic_pkg::cell_link_t  chain [mdic_pkg::HwDims+1];
	logic [mdic_pkg::HwDims:0] carry;
	logic [mdic_pkg::HwDims-1:0] tok_vec;
	logic                  load;
	logic                  hold;
	mdic_pkg::count_t      limit;

	mdic_pkg::count_t      steps_q;
	logic                  out_valid_q;
	mdic_pkg::size_t       index_q [mdic_pkg::HwDims];
	mdic_pkg::count_t      linear_q;
	mdic_pkg::count_t      step_count_q;
	logic                  finished_q;

	mdic_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.size        (cfg_size),
		.step_limit  (step_limit),
		.auto_limit  (auto_limit)
	);

	assign chain[0].tok  = in_valid && in_ready;
	assign chain[0].mask = exclude_mask;
	assign chain[0].acc  = '0;
	assign chain[0].prod = mdic_pkg::CountW'(1);
	assign carry[mdic_pkg::HwDims] = 1'b1;

	for (genvar d = 0; d < mdic_pkg::HwDims; d++) begin : g_cell
		if (d < mdic_pkg::FirstActive) begin : g_fixed
			assign eff_size[d] = mdic_pkg::SizeBits'(1);
		end else begin : g_active
			assign eff_size[d] = cfg_size[d];
		end

		mdic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.size      (eff_size[d]),
			.hold      (hold),
			.adv       (load),
			.carry_in  (carry[d+1]),
			.carry_out (carry[d]),
			.link_in   (chain[d]),
			.link_out  (chain[d+1]),
			.digit     (digit[d])
		);

		assign tok_vec[d] = chain[d+1].tok;
	end

	always_comb begin
		in_ready = ~|tok_vec;
		load     = chain[mdic_pkg::HwDims].tok && (!out_valid_q || out_ready);
		hold     = chain[mdic_pkg::HwDims].tok && !load;
		limit    = auto_limit ? chain[mdic_pkg::HwDims].prod : step_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (steps_q != mdic_pkg::CountMax) begin
					steps_q <= steps_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			index_q      <= digit;
			linear_q     <= chain[mdic_pkg::HwDims].acc;
			step_count_q <= steps_q;
			finished_q   <= steps_q >= limit;
		end
	end

	assign out_valid    = out_valid_q;
	assign index_dim0   = index_q[0];
	assign index_dim1   = index_q[1];
	assign index_dim2   = index_q[2];
	assign index_dim3   = index_q[3];
	assign linear_index = linear_q;
	assign step_count   = step_count_q;
	assign finished     = finished_q;

	`ASSERT_CLK(a_one_txn_in_chain, $onehot0(tok_vec), "more than one transaction in the cell chain")
	`ASSERT_CLK(a_step_advance, load && steps_q != mdic_pkg::CountMax |=> steps_q == $past(steps_q) + 1'b1, "step count did not advance on result load")
	`ASSERT_CLK(a_load_from_chain, $rose(out_valid_q) |-> $past(chain[mdic_pkg::HwDims].tok), "result loaded without a transaction at the chain end")
	`ASSERT_CLK(a_enter_chain, in_valid && in_ready |=> chain[1].tok, "accepted transaction did not enter the first cell")

endmodule

`default_nettype wire
